FILE: hw/rtl/ppd_pkg.sv
// Shared types and constants for the planar primitive distance unit.
package ppd_pkg;

  // Coordinate, fraction and result widths.
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int DIST_BITS  = 25;

  // Derived arithmetic widths.
  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int MAG_W     = SUM_W;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int NUM_RAW_W = SQ_W + 2 * FRAC_BITS;
  localparam int QUO_W     = 2 * DIST_BITS;
  localparam int NUM_W     = (NUM_RAW_W > QUO_W) ? NUM_RAW_W : QUO_W + 1;
  localparam int LANES     = 4;

  // Command codes.
  localparam logic [3:0] CMD_PT_LINE   = 4'd0;
  localparam logic [3:0] CMD_PT_RAY    = 4'd1;
  localparam logic [3:0] CMD_PT_SEG    = 4'd2;
  localparam logic [3:0] CMD_LINE_LINE = 4'd3;
  localparam logic [3:0] CMD_RAY_LINE  = 4'd4;
  localparam logic [3:0] CMD_RAY_RAY   = 4'd5;
  localparam logic [3:0] CMD_SEG_LINE  = 4'd6;
  localparam logic [3:0] CMD_SEG_RAY   = 4'd7;
  localparam logic [3:0] CMD_SEG_SEG   = 4'd8;

  // How a job ends: computed distance, all zero, degenerate or crossing.
  typedef enum logic [1:0] {
    RES_NORMAL,
    RES_NONE,
    RES_DEGEN,
    RES_CROSS
  } res_e;

  // Input word.
  typedef struct packed {
    logic [3:0]                   command;
    logic signed [COORD_BITS-1:0] p_start_x;
    logic signed [COORD_BITS-1:0] p_start_y;
    logic signed [COORD_BITS-1:0] p_end_x;
    logic signed [COORD_BITS-1:0] p_end_y;
    logic signed [COORD_BITS-1:0] q_start_x;
    logic signed [COORD_BITS-1:0] q_start_y;
    logic signed [COORD_BITS-1:0] q_end_x;
    logic signed [COORD_BITS-1:0] q_end_y;
  } in_word_t;

  // Output word.
  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    logic                 touching;
    logic                 status;
  } out_word_t;

  // One candidate distance: mag squared (sq set) or mag itself over den.
  typedef struct packed {
    logic             en;
    logic             sq;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] den;
  } lane_t;

  // Classified job handed from the front end to the back end.
  typedef struct packed {
    res_e                   res;
    lane_t [LANES-1:0]      lane;
  } job_t;

endpackage

FILE: hw/rtl/ppd_front.sv
// Front end: takes words, forms products and classifies each job.
module ppd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ppd_pkg::in_word_t in_word_i,
  output logic             push_o,
  output ppd_pkg::job_t    push_word_o,
  input  logic             full_i
);

  localparam int CB = ppd_pkg::COORD_BITS;
  localparam int DW = ppd_pkg::DIFF_W;
  localparam int PW = ppd_pkg::PROD_W;
  localparam int SW = ppd_pkg::SUM_W;
  localparam int MW = ppd_pkg::MAG_W;
  localparam int NL = ppd_pkg::LANES;

  typedef enum logic [1:0] {KIND_POINT, KIND_LINE, KIND_RAY, KIND_SEG} kind_e;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
  } vec_t;

  typedef struct packed {
    logic signed [PW-1:0] dxvx, dyvy, dxvy, dyvx, vx2, vy2, wx2, wy2;
  } lprod_t;

  typedef struct packed {
    logic signed [PW-1:0] pxx, pyy, qxx, qyy, den_a, den_b, tn_a, tn_b, un_a, un_b;
  } gprod_t;

  typedef struct packed {
    logic signed [SW-1:0] t, c, nv, nw;
  } lsum_t;

  typedef struct packed {
    logic signed [SW-1:0] len2p, len2q, den, tn, un;
  } gsum_t;

  function automatic vec_t vsub(input logic signed [CB-1:0] ax, input logic signed [CB-1:0] ay,
                                input logic signed [CB-1:0] bx, input logic signed [CB-1:0] by);
    vec_t r;
    r.x = DW'(ax) - DW'(bx);
    r.y = DW'(ay) - DW'(by);
    return r;
  endfunction

  function automatic logic signed [PW-1:0] mul(input logic signed [DW-1:0] a,
                                               input logic signed [DW-1:0] b);
    return PW'(a) * PW'(b);
  endfunction

  function automatic logic signed [SW-1:0] add(input logic signed [PW-1:0] a,
                                               input logic signed [PW-1:0] b);
    return SW'(a) + SW'(b);
  endfunction

  function automatic logic signed [SW-1:0] sub(input logic signed [PW-1:0] a,
                                               input logic signed [PW-1:0] b);
    return SW'(a) - SW'(b);
  endfunction

  function automatic kind_e first_kind(input logic [3:0] cmd);
    kind_e k;
    case (cmd)
      ppd_pkg::CMD_PT_LINE, ppd_pkg::CMD_LINE_LINE: k = KIND_LINE;
      ppd_pkg::CMD_PT_RAY, ppd_pkg::CMD_RAY_LINE, ppd_pkg::CMD_RAY_RAY: k = KIND_RAY;
      default: k = KIND_SEG;
    endcase
    return k;
  endfunction

  function automatic kind_e second_kind(input logic [3:0] cmd);
    kind_e k;
    case (cmd)
      ppd_pkg::CMD_LINE_LINE, ppd_pkg::CMD_RAY_LINE, ppd_pkg::CMD_SEG_LINE: k = KIND_LINE;
      ppd_pkg::CMD_RAY_RAY, ppd_pkg::CMD_SEG_RAY: k = KIND_RAY;
      ppd_pkg::CMD_SEG_SEG: k = KIND_SEG;
      default: k = KIND_POINT;
    endcase
    return k;
  endfunction

  // Whether a crossing parameter lies on a primitive of the given kind.
  function automatic logic param_ok(input kind_e k, input logic signed [SW-1:0] num,
                                    input logic signed [SW-1:0] den);
    logic ok;
    case (k)
      KIND_LINE: ok = 1'b1;
      KIND_RAY:  ok = !num[SW-1];
      KIND_SEG:  ok = !num[SW-1] && (num <= den);
      default:   ok = 1'b0;
    endcase
    return ok;
  endfunction

  logic fe;

  logic              s1_vld_q, s2_vld_q, s3_vld_q;
  ppd_pkg::res_e     s1_res_q, s2_res_q, s3_res_q;
  kind_e             s1_pk_q, s2_pk_q, s3_pk_q;
  kind_e             s1_qk_q, s2_qk_q, s3_qk_q;
  logic [NL-1:0]     s1_en_q, s2_en_q, s3_en_q;
  vec_t              s1_dp_q, s1_dq_q;
  vec_t              s1_v_q [NL];
  vec_t              s1_w_q [NL];
  lprod_t            s2_lp_q [NL];
  gprod_t            s2_gp_q;
  lsum_t             s3_ls_q [NL];
  gsum_t             s3_gs_q;

  // Stage one inputs: kinds, degenerate check and difference vectors.
  kind_e         pk_d, qk_d;
  ppd_pkg::res_e res_d;
  logic [NL-1:0] en_d;
  vec_t          dp_d, dq_d;
  vec_t          v_d [NL];
  vec_t          w_d [NL];
  logic          degen;

  always_comb begin
    pk_d  = first_kind(in_word_i.command);
    qk_d  = second_kind(in_word_i.command);
    degen = ((in_word_i.p_start_x == in_word_i.p_end_x) &&
             (in_word_i.p_start_y == in_word_i.p_end_y)) ||
            ((qk_d != KIND_POINT) &&
             (in_word_i.q_start_x == in_word_i.q_end_x) &&
             (in_word_i.q_start_y == in_word_i.q_end_y));
    if (in_word_i.command > ppd_pkg::CMD_SEG_SEG) begin
      res_d = ppd_pkg::RES_NONE;
    end else if (degen) begin
      res_d = ppd_pkg::RES_DEGEN;
    end else begin
      res_d = ppd_pkg::RES_NORMAL;
    end
    // Lanes 0 and 1 measure P's endpoints against Q, lanes 2 and 3 Q's against P.
    en_d[0] = (pk_d != KIND_LINE) && (qk_d != KIND_POINT);
    en_d[1] = (pk_d == KIND_SEG) && (qk_d != KIND_POINT);
    en_d[2] = (qk_d != KIND_LINE) || (pk_d == KIND_LINE);
    en_d[3] = (qk_d == KIND_SEG);
    dp_d = vsub(in_word_i.p_end_x, in_word_i.p_end_y, in_word_i.p_start_x, in_word_i.p_start_y);
    dq_d = vsub(in_word_i.q_end_x, in_word_i.q_end_y, in_word_i.q_start_x, in_word_i.q_start_y);
    v_d[0] = vsub(in_word_i.p_start_x, in_word_i.p_start_y, in_word_i.q_start_x, in_word_i.q_start_y);
    w_d[0] = vsub(in_word_i.p_start_x, in_word_i.p_start_y, in_word_i.q_end_x, in_word_i.q_end_y);
    v_d[1] = vsub(in_word_i.p_end_x, in_word_i.p_end_y, in_word_i.q_start_x, in_word_i.q_start_y);
    w_d[1] = vsub(in_word_i.p_end_x, in_word_i.p_end_y, in_word_i.q_end_x, in_word_i.q_end_y);
    v_d[2] = vsub(in_word_i.q_start_x, in_word_i.q_start_y, in_word_i.p_start_x, in_word_i.p_start_y);
    w_d[2] = vsub(in_word_i.q_start_x, in_word_i.q_start_y, in_word_i.p_end_x, in_word_i.p_end_y);
    v_d[3] = vsub(in_word_i.q_end_x, in_word_i.q_end_y, in_word_i.p_start_x, in_word_i.p_start_y);
    w_d[3] = vsub(in_word_i.q_end_x, in_word_i.q_end_y, in_word_i.p_end_x, in_word_i.p_end_y);
  end

  // Stage two inputs: all products, one multiplier each.
  lprod_t lp_d [NL];
  gprod_t gp_d;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      vec_t d;
      d = (l < 2) ? s1_dq_q : s1_dp_q;
      lp_d[l].dxvx = mul(d.x, s1_v_q[l].x);
      lp_d[l].dyvy = mul(d.y, s1_v_q[l].y);
      lp_d[l].dxvy = mul(d.x, s1_v_q[l].y);
      lp_d[l].dyvx = mul(d.y, s1_v_q[l].x);
      lp_d[l].vx2  = mul(s1_v_q[l].x, s1_v_q[l].x);
      lp_d[l].vy2  = mul(s1_v_q[l].y, s1_v_q[l].y);
      lp_d[l].wx2  = mul(s1_w_q[l].x, s1_w_q[l].x);
      lp_d[l].wy2  = mul(s1_w_q[l].y, s1_w_q[l].y);
    end
    gp_d.pxx   = mul(s1_dp_q.x, s1_dp_q.x);
    gp_d.pyy   = mul(s1_dp_q.y, s1_dp_q.y);
    gp_d.qxx   = mul(s1_dq_q.x, s1_dq_q.x);
    gp_d.qyy   = mul(s1_dq_q.y, s1_dq_q.y);
    gp_d.den_a = mul(s1_dp_q.x, s1_dq_q.y);
    gp_d.den_b = mul(s1_dp_q.y, s1_dq_q.x);
    gp_d.tn_a  = mul(s1_v_q[2].x, s1_dq_q.y);
    gp_d.tn_b  = mul(s1_v_q[2].y, s1_dq_q.x);
    gp_d.un_a  = mul(s1_v_q[2].x, s1_dp_q.y);
    gp_d.un_b  = mul(s1_v_q[2].y, s1_dp_q.x);
  end

  // Stage three inputs: dot products, cross products and squared lengths.
  lsum_t ls_d [NL];
  gsum_t gs_d;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      ls_d[l].t  = add(s2_lp_q[l].dxvx, s2_lp_q[l].dyvy);
      ls_d[l].c  = sub(s2_lp_q[l].dxvy, s2_lp_q[l].dyvx);
      ls_d[l].nv = add(s2_lp_q[l].vx2, s2_lp_q[l].vy2);
      ls_d[l].nw = add(s2_lp_q[l].wx2, s2_lp_q[l].wy2);
    end
    gs_d.len2p = add(s2_gp_q.pxx, s2_gp_q.pyy);
    gs_d.len2q = add(s2_gp_q.qxx, s2_gp_q.qyy);
    gs_d.den   = sub(s2_gp_q.den_a, s2_gp_q.den_b);
    gs_d.tn    = sub(s2_gp_q.tn_a, s2_gp_q.tn_b);
    gs_d.un    = sub(s2_gp_q.un_a, s2_gp_q.un_b);
  end

  // Classification: crossing test and choice of each lane's distance form.
  logic signed [SW-1:0] den_n, tn_n, un_n;
  logic                 crossing;

  always_comb begin
    if (s3_gs_q.den[SW-1]) begin
      den_n = -s3_gs_q.den;
      tn_n  = -s3_gs_q.tn;
      un_n  = -s3_gs_q.un;
    end else begin
      den_n = s3_gs_q.den;
      tn_n  = s3_gs_q.tn;
      un_n  = s3_gs_q.un;
    end
    crossing = (s3_qk_q != KIND_POINT) && (s3_gs_q.den != '0) &&
               param_ok(s3_pk_q, tn_n, den_n) && param_ok(s3_qk_q, un_n, den_n);
    if ((s3_res_q == ppd_pkg::RES_NORMAL) && crossing) begin
      push_word_o.res = ppd_pkg::RES_CROSS;
    end else begin
      push_word_o.res = s3_res_q;
    end
    for (int l = 0; l < NL; l++) begin
      kind_e                k;
      logic signed [SW-1:0] len2;
      k    = (l < 2) ? s3_qk_q : s3_pk_q;
      len2 = (l < 2) ? s3_gs_q.len2q : s3_gs_q.len2p;
      push_word_o.lane[l].en = s3_en_q[l] && (push_word_o.res == ppd_pkg::RES_NORMAL);
      if ((k inside {KIND_RAY, KIND_SEG}) &&
          (s3_ls_q[l].t[SW-1] || (s3_ls_q[l].t == '0))) begin
        push_word_o.lane[l].sq  = 1'b0;
        push_word_o.lane[l].mag = s3_ls_q[l].nv;
        push_word_o.lane[l].den = MW'(1);
      end else if ((k == KIND_SEG) && (s3_ls_q[l].t >= len2)) begin
        push_word_o.lane[l].sq  = 1'b0;
        push_word_o.lane[l].mag = s3_ls_q[l].nw;
        push_word_o.lane[l].den = MW'(1);
      end else begin
        push_word_o.lane[l].sq  = 1'b1;
        push_word_o.lane[l].mag = s3_ls_q[l].c[SW-1] ? -s3_ls_q[l].c : s3_ls_q[l].c;
        push_word_o.lane[l].den = len2;
      end
    end
  end

  // The whole front end halts while its last word waits on a full queue.
  assign fe         = !(s3_vld_q && full_i);
  assign in_stall_o = !fe;
  assign push_o     = s3_vld_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (fe) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fe) begin
      s1_res_q <= res_d;
      s1_pk_q  <= pk_d;
      s1_qk_q  <= qk_d;
      s1_en_q  <= en_d;
      s1_dp_q  <= dp_d;
      s1_dq_q  <= dq_d;
      s1_v_q   <= v_d;
      s1_w_q   <= w_d;
      s2_res_q <= s1_res_q;
      s2_pk_q  <= s1_pk_q;
      s2_qk_q  <= s1_qk_q;
      s2_en_q  <= s1_en_q;
      s2_lp_q  <= lp_d;
      s2_gp_q  <= gp_d;
      s3_res_q <= s2_res_q;
      s3_pk_q  <= s2_pk_q;
      s3_qk_q  <= s2_qk_q;
      s3_en_q  <= s2_en_q;
      s3_ls_q  <= ls_d;
      s3_gs_q  <= gs_d;
    end
  end

endmodule

FILE: hw/rtl/ppd_queue.sv
// Short job queue between the front end and the back end.
module ppd_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ppd_pkg::job_t push_word_i,
  output logic          full_o,
  output logic          valid_o,
  output ppd_pkg::job_t word_o,
  input  logic          pop_i
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ppd_pkg::job_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign word_o  = mem_q[rd_ptr_q];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  // The front end never writes into a full queue.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");

  // The back end never reads an empty queue.
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue read while empty");

  // Occupancy grows by one on a lone push.
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow");

  // Occupancy shrinks by one on a lone pop.
  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !push_i) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count did not shrink");

endmodule

FILE: hw/rtl/ppd_back.sv
// Back end: squares, long division per lane, minimum and square root.
module ppd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  ppd_pkg::job_t      job_word_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ppd_pkg::out_word_t out_word_o
);

  localparam int MW    = ppd_pkg::MAG_W;
  localparam int SQW   = ppd_pkg::SQ_W;
  localparam int NW    = ppd_pkg::NUM_W;
  localparam int QW    = ppd_pkg::QUO_W;
  localparam int DB    = ppd_pkg::DIST_BITS;
  localparam int NL    = ppd_pkg::LANES;
  localparam int H     = (MW + 1) / 2;
  localparam int HI_W  = MW - H;
  localparam int TOP_W = NW - QW;
  localparam int CMP_W = (TOP_W > MW) ? TOP_W : MW;

  typedef struct packed {
    ppd_pkg::res_e res;
    logic          zero;
  } meta_t;

  typedef struct packed {
    logic                 en;
    logic                 sq;
    logic [MW-1:0]        mag;
    logic [MW-1:0]        den;
    logic [2*H-1:0]       ll;
    logic [H+HI_W-1:0]    lh;
    logic [2*HI_W-1:0]    hh;
  } b1_lane_t;

  typedef struct packed {
    logic           en;
    logic [SQW-1:0] num;
    logic [MW-1:0]  den;
  } b2_lane_t;

  typedef struct packed {
    logic          sat;
    logic [MW-1:0] rem;
    logic [MW-1:0] den;
    logic [QW-1:0] low;
    logic [QW-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [QW-1:0] rem;
    logic [DB-1:0] root;
  } sq_t;

  logic be;

  logic      b1_vld_q, b2_vld_q, m1_vld_q, out_vld_q;
  meta_t     b1_meta_q, b2_meta_q, m1_meta_q;
  b1_lane_t  b1_q [NL];
  b2_lane_t  b2_q [NL];
  logic      dv_vld_q [QW+1];
  meta_t     dv_meta_q [QW+1];
  div_t      dv_q [QW+1][NL];
  logic [QW-1:0] m1_a_q, m1_b_q;
  logic      sq_vld_q [DB+1];
  meta_t     sq_meta_q [DB+1];
  sq_t       sq_q [DB+1];
  ppd_pkg::out_word_t out_q;

  // The pipeline advances unless a finished word is held by the consumer.
  assign be          = !(out_vld_q && out_stall_i);
  assign pop_o       = be && job_valid_i;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  // Square partial products and the touch flag.
  b1_lane_t b1_d [NL];
  meta_t    b1_meta_d;

  always_comb begin
    b1_meta_d.res  = job_word_i.res;
    b1_meta_d.zero = 1'b0;
    for (int l = 0; l < NL; l++) begin
      logic [H-1:0]    lo;
      logic [HI_W-1:0] hi;
      lo = job_word_i.lane[l].mag[H-1:0];
      hi = job_word_i.lane[l].mag[MW-1:H];
      b1_d[l].en  = job_word_i.lane[l].en;
      b1_d[l].sq  = job_word_i.lane[l].sq;
      b1_d[l].mag = job_word_i.lane[l].mag;
      b1_d[l].den = job_word_i.lane[l].den;
      b1_d[l].ll  = (2*H)'(lo) * (2*H)'(lo);
      b1_d[l].lh  = (H+HI_W)'(lo) * (H+HI_W)'(hi);
      b1_d[l].hh  = (2*HI_W)'(hi) * (2*HI_W)'(hi);
      if (job_word_i.lane[l].en && (job_word_i.lane[l].mag == '0)) begin
        b1_meta_d.zero = 1'b1;
      end
    end
  end

  // Numerators: the square summed from its parts, or the squared length.
  b2_lane_t b2_d [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      b2_d[l].en  = b1_q[l].en;
      b2_d[l].den = b1_q[l].den;
      if (b1_q[l].sq) begin
        b2_d[l].num = (SQW'(b1_q[l].hh) << (2*H)) + (SQW'(b1_q[l].lh) << (H+1)) +
                      SQW'(b1_q[l].ll);
      end else begin
        b2_d[l].num = SQW'(b1_q[l].mag);
      end
    end
  end

  // Division entry: scale, test for saturation and load the remainder.
  div_t dv0_d [NL];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      logic [NW-1:0]    nsh;
      logic [TOP_W-1:0] top;
      nsh = NW'(b2_q[l].num) << (2*ppd_pkg::FRAC_BITS);
      top = nsh[NW-1:QW];
      dv0_d[l].sat = !b2_q[l].en || (CMP_W'(top) >= CMP_W'(b2_q[l].den));
      dv0_d[l].rem = MW'(top);
      dv0_d[l].den = b2_q[l].den;
      dv0_d[l].low = nsh[QW-1:0];
      dv0_d[l].quo = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q    <= 1'b0;
      b2_vld_q    <= 1'b0;
      dv_vld_q[0] <= 1'b0;
    end else if (be) begin
      b1_vld_q    <= job_valid_i;
      b2_vld_q    <= b1_vld_q;
      dv_vld_q[0] <= b2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      b1_q         <= b1_d;
      b1_meta_q    <= b1_meta_d;
      b2_q         <= b2_d;
      b2_meta_q    <= b1_meta_q;
      dv_q[0]      <= dv0_d;
      dv_meta_q[0] <= b2_meta_q;
    end
  end

  // Restoring division, one quotient bit per stage and lane.
  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int BIT = QW - 1 - s;
    div_t nxt [NL];

    always_comb begin
      for (int l = 0; l < NL; l++) begin
        logic [MW:0] r2;
        logic        ge;
        r2  = {dv_q[s][l].rem, dv_q[s][l].low[BIT]};
        ge  = (r2 >= {1'b0, dv_q[s][l].den});
        nxt[l]          = dv_q[s][l];
        nxt[l].rem      = ge ? MW'(r2 - {1'b0, dv_q[s][l].den}) : MW'(r2);
        nxt[l].quo[BIT] = ge;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[s+1] <= 1'b0;
      end else if (be) begin
        dv_vld_q[s+1] <= dv_vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (be) begin
        dv_q[s+1]      <= nxt;
        dv_meta_q[s+1] <= dv_meta_q[s];
      end
    end
  end

  // Smallest squared ratio over the lanes, as a two-level registered tree.
  logic [QW-1:0] fin [NL];
  logic [QW-1:0] m1_a_d, m1_b_d;
  sq_t           sq0_d;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      fin[l] = dv_q[QW][l].sat ? '1 : dv_q[QW][l].quo;
    end
    m1_a_d     = (fin[1] < fin[0]) ? fin[1] : fin[0];
    m1_b_d     = (fin[3] < fin[2]) ? fin[3] : fin[2];
    sq0_d.rem  = (m1_b_q < m1_a_q) ? m1_b_q : m1_a_q;
    sq0_d.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q    <= 1'b0;
      sq_vld_q[0] <= 1'b0;
    end else if (be) begin
      m1_vld_q    <= dv_vld_q[QW];
      sq_vld_q[0] <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      m1_a_q       <= m1_a_d;
      m1_b_q       <= m1_b_d;
      m1_meta_q    <= dv_meta_q[QW];
      sq_q[0]      <= sq0_d;
      sq_meta_q[0] <= m1_meta_q;
    end
  end

  // Digit-by-digit square root, one result bit per stage.
  for (genvar s = 0; s < DB; s++) begin : g_sqrt
    localparam int BIT = DB - 1 - s;
    sq_t          nxt;
    logic [QW:0]  trial;
    logic         ge;

    always_comb begin
      trial = ((QW+1)'(sq_q[s].root) << (BIT + 1)) + ((QW+1)'(1) << (2*BIT));
      ge    = ({1'b0, sq_q[s].rem} >= trial);
      nxt   = sq_q[s];
      if (ge) begin
        nxt.rem       = QW'({1'b0, sq_q[s].rem} - trial);
        nxt.root[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[s+1] <= 1'b0;
      end else if (be) begin
        sq_vld_q[s+1] <= sq_vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (be) begin
        sq_q[s+1]      <= nxt;
        sq_meta_q[s+1] <= sq_meta_q[s];
      end
    end
  end

  // Output word by job outcome.
  ppd_pkg::out_word_t out_d;

  always_comb begin
    out_d = '0;
    case (sq_meta_q[DB].res)
      ppd_pkg::RES_NORMAL: begin
        out_d.touching = sq_meta_q[DB].zero;
        out_d.distance = sq_meta_q[DB].zero ? '0 : sq_q[DB].root;
      end
      ppd_pkg::RES_CROSS: out_d.touching = 1'b1;
      ppd_pkg::RES_DEGEN: out_d.status = 1'b1;
      default:            out_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (be) begin
      out_vld_q <= sq_vld_q[DB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (be) begin
      out_q <= out_d;
    end
  end

  // A touching result always reports zero distance.
  a_touch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.touching) |-> (out_q.distance == '0))
    else $error("touching word with nonzero distance");

  // A degenerate result never reports touching.
  a_degen_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.status) |-> !out_q.touching)
    else $error("degenerate word flagged as touching");

endmodule

FILE: hw/rtl/planar_primitive_distance_unit.sv
// Top level: distance between two planar primitives given by integer points.
// Throughput: one word per cycle unless stalled; the three-stage front end and the long
// division and square-root pipeline of the back end each take a new word every cycle.
// Reset clears all valid flags and the queue pointers; no result is pending after reset.
module planar_primitive_distance_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ppd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ppd_pkg::out_word_t out_word_o
);

  logic          push, full, job_valid, pop;
  ppd_pkg::job_t push_word, job_word;

  // Front end: products and classification.
  ppd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .push_o      (push),
    .push_word_o (push_word),
    .full_i      (full)
  );

  // Queue between the two halves.
  ppd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (push_word),
    .full_o      (full),
    .valid_o     (job_valid),
    .word_o      (job_word),
    .pop_i       (pop)
  );

  // Back end: division, minimum and square root.
  ppd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_word_i  (job_word),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
